/* rtl/tcw_pkg.sv */
`default_nettype none

package tcw_pkg;

    // field widths fixed by the channel formats
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int IDX_W  = 11;
    localparam int POS_W  = 11;

    // character and attribute codes
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'b00000010;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT     = 2'd0,
        CMD_NEWLINE = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_READ    = 2'd3
    } tcw_cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_BLANK,
        ST_PUT,
        ST_READ,
        ST_RESP
    } tcw_state_t;

    // one screen cell: attribute in the upper byte
    typedef struct packed {
        logic [ATTR_W-1:0] attr;
        logic [CHAR_W-1:0] code;
    } tcw_cell_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  read_index;
    } tcw_in_t;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_pos;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
    } tcw_out_t;

endpackage

`default_nettype wire

/* rtl/tcw_screen_mem.sv */
`default_nettype none

module tcw_screen_mem
    import tcw_pkg::*;
#(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  wire logic      aclk,
    input  wire logic      wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire tcw_cell_t wr_data,
    input  wire logic      rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output tcw_cell_t      rd_data
);

    tcw_cell_t mem [DEPTH];
    tcw_cell_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/text_console_writer_top.sv */
// results: put character and new line without scrolling register their result in the
//   cycle after the request, read cell passes the memory read register and then the result
//   register; scroll blanks COLS cells first, clear ROWS*COLS, via the single write port
// throughput: one put or new line per cycle while results are taken and no scroll is due
// reset: synchronous active-low aresetn; afterwards the screen memory is blanked, one cell
//   a cycle with s_ready low, through all ROWS*COLS cells; cursor at 0, attribute 2
`default_nettype none

module text_console_writer_top
    import tcw_pkg::*;
#(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire tcw_in_t           s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output tcw_out_t               m_data,
    input  wire logic              cfg_we,
    input  wire logic [ATTR_W-1:0] cfg_wdata
);

    localparam int CELLS = ROWS * COLS;
    localparam int CW    = $clog2(CELLS + 1);
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int CLW   = $clog2(COLS);
    localparam int RSW   = ((CW > IDX_W) ? CW : IDX_W) + 1;

    tcw_state_t        state_reg, state_next;
    logic [RW-1:0]     cur_row_reg, cur_row_next;
    logic [CLW-1:0]    cur_col_reg, cur_col_next;
    logic [CW-1:0]     cur_lin_reg, cur_lin_next;
    logic [AW-1:0]     offset_reg, offset_next;
    logic [AW-1:0]     sweep_addr_reg, sweep_addr_next;
    logic [AW-1:0]     sweep_end_reg, sweep_end_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              put_pend_reg, put_pend_next;
    logic              rd_zero_reg, rd_zero_next;
    logic [ATTR_W-1:0] attr_reg, attr_next;
    logic              m_valid_reg, m_valid_next;
    tcw_out_t          m_data_reg, m_data_next;

    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    tcw_cell_t         wr_data, rd_data;

    logic              out_free, past_end;
    logic [CHAR_W-1:0] put_char;
    logic              put_nl;
    logic [RW-1:0]     put_row;
    logic [CLW-1:0]    put_col;
    logic [CW-1:0]     put_lin, nl_lin;
    logic [CW:0]       cur_sum;
    logic [AW-1:0]     cur_phys;
    logic [RSW-1:0]    rd_sum;
    logic [AW-1:0]     rd_phys;
    logic              rd_in_range;
    logic [CW-1:0]     offset_adv;

    tcw_screen_mem #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign past_end = (cur_row_reg == RW'(ROWS));

    // cursor to physical cell, screen rows are rotated by offset
    always_comb begin
        cur_sum  = (CW+1)'(cur_lin_reg) + (CW+1)'(offset_reg);
        cur_phys = (cur_sum >= (CW+1)'(CELLS)) ? AW'(cur_sum - (CW+1)'(CELLS))
                                               : AW'(cur_sum);
    end

    // read index to physical cell
    always_comb begin
        rd_in_range = (RSW'(s_data.read_index) < RSW'(CELLS));
        rd_sum      = RSW'(s_data.read_index) + RSW'(offset_reg);
        rd_phys     = (rd_sum >= RSW'(CELLS)) ? AW'(rd_sum - RSW'(CELLS)) : AW'(rd_sum);
    end

    // scroll moves the top row pointer one row down
    always_comb begin
        offset_adv = CW'(offset_reg) + CW'(COLS);
        if (offset_adv == CW'(CELLS)) begin
            offset_adv = '0;
        end
    end

    // cursor update for a put that needs no scroll
    always_comb begin
        put_char = (state_reg == ST_PUT) ? char_reg : s_data.char_code;
        put_nl   = (put_char == NEWLINE_CODE);
        nl_lin   = cur_lin_reg - CW'(cur_col_reg) + CW'(COLS);
        if (put_nl) begin
            put_row = cur_row_reg + RW'(1);
            put_col = '0;
            put_lin = nl_lin;
        end else if (cur_col_reg == CLW'(COLS - 1)) begin
            put_row = cur_row_reg + RW'(1);
            put_col = '0;
            put_lin = cur_lin_reg + CW'(1);
        end else begin
            put_row = cur_row_reg;
            put_col = cur_col_reg + CLW'(1);
            put_lin = cur_lin_reg + CW'(1);
        end
    end

    // state register and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            cur_lin_reg    <= '0;
            offset_reg     <= '0;
            sweep_addr_reg <= '0;
            sweep_end_reg  <= AW'(CELLS - 1);
            put_pend_reg   <= 1'b0;
            rd_zero_reg    <= 1'b0;
            attr_reg       <= RESET_ATTR;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            cur_lin_reg    <= cur_lin_next;
            offset_reg     <= offset_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_end_reg  <= sweep_end_next;
            put_pend_reg   <= put_pend_next;
            rd_zero_reg    <= rd_zero_next;
            attr_reg       <= attr_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        char_reg   <= char_next;
        m_data_reg <= m_data_next;
    end

    // next state, memory accesses and result
    always_comb begin
        state_next      = state_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        cur_lin_next    = cur_lin_reg;
        offset_next     = offset_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_end_next  = sweep_end_reg;
        char_next       = char_reg;
        put_pend_next   = put_pend_reg;
        rd_zero_next    = rd_zero_reg;
        attr_next       = cfg_we ? cfg_wdata : attr_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        s_ready         = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;

        case (state_reg)
            ST_INIT: begin
                wr_en        = 1'b1;
                wr_addr      = sweep_addr_reg;
                wr_data.attr = RESET_ATTR;
                wr_data.code = BLANK_CODE;
                if (sweep_addr_reg == sweep_end_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    sweep_addr_next = sweep_addr_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                s_ready = out_free;
                if (s_valid && out_free) begin
                    case (tcw_cmd_t'(s_data.cmd))
                        CMD_PUT: begin
                            if (past_end) begin
                                // scroll first, the put follows the row blanking
                                cur_row_next    = RW'(ROWS - 1);
                                cur_col_next    = '0;
                                cur_lin_next    = CW'(CELLS - COLS);
                                sweep_addr_next = offset_reg;
                                sweep_end_next  = offset_reg + AW'(COLS - 1);
                                offset_next     = AW'(offset_adv);
                                char_next       = s_data.char_code;
                                put_pend_next   = 1'b1;
                                state_next      = ST_BLANK;
                            end else begin
                                wr_en        = !put_nl;
                                wr_addr      = cur_phys;
                                wr_data.attr = attr_reg;
                                wr_data.code = put_char;
                                cur_row_next = put_row;
                                cur_col_next = put_col;
                                cur_lin_next = put_lin;
                                m_valid_next = 1'b1;
                                m_data_next  = '{cursor_pos: POS_W'(put_lin),
                                                 cell_char: '0, cell_attr: '0};
                            end
                        end
                        CMD_NEWLINE: begin
                            if (cur_row_reg >= RW'(ROWS - 1)) begin
                                // move lands past the end, scroll
                                cur_row_next    = RW'(ROWS - 1);
                                cur_col_next    = '0;
                                cur_lin_next    = CW'(CELLS - COLS);
                                sweep_addr_next = offset_reg;
                                sweep_end_next  = offset_reg + AW'(COLS - 1);
                                offset_next     = AW'(offset_adv);
                                put_pend_next   = 1'b0;
                                state_next      = ST_BLANK;
                            end else begin
                                cur_row_next = cur_row_reg + RW'(1);
                                cur_col_next = '0;
                                cur_lin_next = nl_lin;
                                m_valid_next = 1'b1;
                                m_data_next  = '{cursor_pos: POS_W'(nl_lin),
                                                 cell_char: '0, cell_attr: '0};
                            end
                        end
                        CMD_CLEAR: begin
                            cur_row_next    = '0;
                            cur_col_next    = '0;
                            cur_lin_next    = '0;
                            offset_next     = '0;
                            sweep_addr_next = '0;
                            sweep_end_next  = AW'(CELLS - 1);
                            put_pend_next   = 1'b0;
                            state_next      = ST_BLANK;
                        end
                        CMD_READ: begin
                            rd_en        = 1'b1;
                            rd_addr      = rd_phys;
                            rd_zero_next = !rd_in_range;
                            state_next   = ST_READ;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_BLANK: begin
                wr_en        = 1'b1;
                wr_addr      = sweep_addr_reg;
                wr_data.attr = attr_reg;
                wr_data.code = BLANK_CODE;
                if (sweep_addr_reg == sweep_end_reg) begin
                    state_next = put_pend_reg ? ST_PUT : ST_RESP;
                end else begin
                    sweep_addr_next = sweep_addr_reg + AW'(1);
                end
            end
            ST_PUT: begin
                // deferred put after a scroll
                if (out_free) begin
                    wr_en        = !put_nl;
                    wr_addr      = cur_phys;
                    wr_data.attr = attr_reg;
                    wr_data.code = put_char;
                    cur_row_next = put_row;
                    cur_col_next = put_col;
                    cur_lin_next = put_lin;
                    m_valid_next = 1'b1;
                    m_data_next  = '{cursor_pos: POS_W'(put_lin),
                                     cell_char: '0, cell_attr: '0};
                    state_next   = ST_IDLE;
                end
            end
            ST_READ: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next.cursor_pos = POS_W'(cur_lin_reg);
                    m_data_next.cell_char  = rd_zero_reg ? '0 : rd_data.code;
                    m_data_next.cell_attr  = rd_zero_reg ? '0 : rd_data.attr;
                    state_next   = ST_IDLE;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{cursor_pos: POS_W'(cur_lin_reg),
                                     cell_char: '0, cell_attr: '0};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // linear cursor tracks row and column
    a_cursor_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(cur_lin_reg) == int'(cur_row_reg) * COLS + int'(cur_col_reg))
        else $error("cursor index out of step with row and column");

    // row never beyond the end, and past the end only at column zero
    a_past_end_col: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_row_reg <= RW'(ROWS)) && (!past_end || cur_col_reg == '0))
        else $error("cursor beyond the last row");

    // top row pointer stays inside the screen
    a_offset_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(offset_reg) < CELLS)
        else $error("row offset outside the screen");

    // an accepted read goes to the read wait with no write pending
    a_read_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.cmd == CMD_READ) |=>
            (state_reg == ST_READ) && !wr_en)
        else $error("read request lost its read cycle");

endmodule

`default_nettype wire
